// File: src/assert_macros.svh
// Assertion macros for the stream parser RTL.
// Included by iff8sp_core, which carries the concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/iff8sp_pkg.sv
// Types and constants for the IFF 8SVX stream parser.
// Used by the parser core, the output register and the top level.
package iff8sp_pkg;

    // Event codes carried in the result tuser field.
    typedef enum logic [2:0] {
        KIND_HEADER   = 3'd0,
        KIND_TEXT     = 3'd1,
        KIND_SAMPLE   = 3'd2,
        KIND_NOT_FORM = 3'd3,
        KIND_NOT_8SVX = 3'd4,
        KIND_END      = 3'd5
    } kind_t;

    // Four-character chunk identifiers, big-endian.
    localparam logic [31:0] TAG_FORM = 32'h464F_524D;
    localparam logic [31:0] TAG_8SVX = 32'h3853_5658;
    localparam logic [31:0] TAG_VHDR = 32'h5648_4452;
    localparam logic [31:0] TAG_BODY = 32'h424F_4459;
    localparam logic [31:0] TAG_ANNO = 32'h414E_4E4F;
    localparam logic [31:0] TAG_NAME = 32'h4E41_4D45;
    localparam logic [31:0] TAG_AUTH = 32'h4155_5448;
    localparam logic [31:0] TAG_COPY = 32'h434F_5059;

    // Voice header size in bytes.
    localparam logic [4:0] VHDR_BYTES = 5'd20;

    // Result of one parsed byte, from the core to the output register.
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] payload;
        logic [3:0] octave;
        logic       done;
    } result_t;

    // Stored voice header words.
    typedef struct packed {
        logic [31:0] oneshot;
        logic [31:0] repeats;
        logic [31:0] cycle;
        logic [31:0] rate_oct_comp;
        logic [31:0] volume;
    } header_t;

endpackage

// File: src/iff_8svx_stream_parser_unit.sv
// Top level of the IFF 8SVX stream parser.
// Depends on iff8sp_pkg, iff8sp_core and iff8sp_out_reg.
//
// Usage:
//   The slave channel takes the file one byte per word in s_tdata; s_tlast
//   marks the last byte of the stream. The master channel gives at most one
//   word per input byte: m_tuser holds the event code (voice header ready,
//   text byte, sample byte, not FORM, not 8SVX, end), m_tdata the text or
//   sample byte, its octave and the stored voice header, and m_tlast is set
//   on the word that ends the parse.
//   Throughput is one byte per cycle while s_tready is high, set by the
//   single pass of parse logic between the accepted byte and the result
//   register. The result word of an accepted byte shows in the next cycle.
//   When the receiver stalls, the waiting word holds and s_tready drops
//   until it is taken; a word can be taken and a new byte accepted in the
//   same cycle.
//   Reset (aresetn low, synchronous) returns the parser to waiting for the
//   FORM id, clears the voice header and empties the result register. After
//   the parse ends, further bytes are accepted and dropped until reset.
module iff_8svx_stream_parser_unit #(
    parameter int MAX_OCTAVES = 10
) (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: [7:0] stream_byte
    input  logic [7:0]   s_tdata,
    input  logic         s_tlast,
    input  logic         s_tvalid,
    output logic         s_tready,
    // m_tdata: [7:0] payload_byte, [11:8] octave_number, [43:12] oneshot_count,
    //   [75:44] repeat_count, [107:76] cycle_samples, [123:108] sample_rate,
    //   [131:124] octave_total, [139:132] compression_code,
    //   [171:140] volume_word, [186:172] nyquist_rate, [191:187] zero
    output logic [191:0] m_tdata,
    // m_tuser: [2:0] event_kind
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    output logic         m_tvalid,
    input  logic         m_tready
);

    logic                s_accept;
    iff8sp_pkg::result_t core_res;
    iff8sp_pkg::result_t out_res;
    iff8sp_pkg::header_t hdr;

    assign s_accept = s_tvalid && s_tready;

    iff8sp_core #(
        .MAX_OCTAVES(MAX_OCTAVES)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (s_accept),
        .in_byte  (s_tdata),
        .in_final (s_tlast),
        .res      (core_res),
        .hdr      (hdr)
    );

    iff8sp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_en   (s_accept),
        .res_in    (core_res),
        .out_ready (m_tready),
        .in_ready  (s_tready),
        .res_out   (out_res)
    );

    // The header only changes on accepted bytes, which a stalled word blocks.
    assign m_tvalid = out_res.valid;
    assign m_tuser  = out_res.kind;
    assign m_tlast  = out_res.done;
    assign m_tdata  = {5'd0,
                       hdr.rate_oct_comp[31:17],
                       hdr.volume,
                       hdr.rate_oct_comp[7:0],
                       hdr.rate_oct_comp[15:8],
                       hdr.rate_oct_comp[31:16],
                       hdr.cycle,
                       hdr.repeats,
                       hdr.oneshot,
                       out_res.octave,
                       out_res.payload};

endmodule

// File: src/iff8sp_core.sv
// Parser state machine for the IFF 8SVX stream parser: one accepted byte per cycle.
// Depends on iff8sp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module iff8sp_core #(
    parameter int MAX_OCTAVES = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                in_final,
    output iff8sp_pkg::result_t res,
    output iff8sp_pkg::header_t hdr
);

    typedef enum logic [3:0] {
        PH_FORM_ID   = 4'd0,
        PH_FORM_LEN  = 4'd1,
        PH_TYPE_ID   = 4'd2,
        PH_CHUNK_HDR = 4'd3,
        PH_VHDR      = 4'd4,
        PH_TEXT      = 4'd5,
        PH_SKIP      = 4'd6,
        PH_BODY      = 4'd7,
        PH_DONE      = 4'd8
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] field_shift_reg, field_shift_next;
    logic [4:0]  byte_index_reg, byte_index_next;
    logic [31:0] form_length_reg, form_length_next;
    logic [31:0] running_total_reg, running_total_next;
    logic [31:0] chunk_tag_reg, chunk_tag_next;
    logic [31:0] chunk_remaining_reg, chunk_remaining_next;
    logic [31:0] hs_reg [5];
    logic [31:0] hs_next [5];
    logic [35:0] body_remaining_reg, body_remaining_next;
    logic [35:0] oct_len_reg, oct_len_next;
    logic [3:0]  current_octave_reg, current_octave_next;

    logic [4:0]  bi_inc;
    logic [31:0] total_sum;
    logic [31:0] end_total;
    logic [31:0] unit;
    logic [7:0]  oct_count;
    logic [7:0]  oct_used;
    logic [4:0]  oct_following;
    logic [2:0]  hs_index;
    logic        do_chunk_end;
    logic        ending;
    logic        has_res;
    iff8sp_pkg::kind_t res_kind;
    logic [7:0]  res_payload;
    logic [3:0]  res_octave;

    // Values used by one or more phases.
    assign bi_inc        = byte_index_reg + 5'd1;
    assign total_sum     = running_total_reg + field_shift_next;
    assign unit          = hs_reg[0] + hs_reg[1];
    assign oct_count     = hs_reg[3][15:8];
    assign oct_used      = (oct_count > 8'(MAX_OCTAVES)) ? 8'(MAX_OCTAVES) : oct_count;
    assign oct_following = {1'b0, current_octave_reg} + 5'd1;
    assign hs_index      = bi_inc[4:2] - 3'd1;

    // Next-state logic for one accepted byte.
    always_comb begin
        phase_next           = phase_reg;
        field_shift_next     = field_shift_reg;
        byte_index_next      = byte_index_reg;
        form_length_next     = form_length_reg;
        running_total_next   = running_total_reg;
        chunk_tag_next       = chunk_tag_reg;
        chunk_remaining_next = chunk_remaining_reg;
        for (int i = 0; i < 5; i++) begin
            hs_next[i] = hs_reg[i];
        end
        body_remaining_next  = body_remaining_reg;
        oct_len_next         = oct_len_reg;
        current_octave_next  = current_octave_reg;
        do_chunk_end         = 1'b0;
        end_total            = running_total_reg;
        ending               = 1'b0;
        has_res              = 1'b0;
        res_kind             = iff8sp_pkg::KIND_END;
        res_payload          = 8'd0;
        res_octave           = 4'd0;

        if (accept && phase_reg != PH_DONE) begin
            field_shift_next = {field_shift_reg[23:0], in_byte};

            case (phase_reg)
                PH_FORM_ID: begin
                    byte_index_next = bi_inc;
                    if (bi_inc == 5'd4) begin
                        byte_index_next = 5'd0;
                        if (field_shift_next == iff8sp_pkg::TAG_FORM) begin
                            phase_next = PH_FORM_LEN;
                        end else begin
                            has_res  = 1'b1;
                            res_kind = iff8sp_pkg::KIND_NOT_FORM;
                            ending   = 1'b1;
                        end
                    end
                end
                PH_FORM_LEN: begin
                    byte_index_next = bi_inc;
                    if (bi_inc == 5'd4) begin
                        byte_index_next  = 5'd0;
                        form_length_next = field_shift_next;
                        phase_next       = PH_TYPE_ID;
                    end
                end
                PH_TYPE_ID: begin
                    byte_index_next = bi_inc;
                    if (bi_inc == 5'd4) begin
                        byte_index_next = 5'd0;
                        if (field_shift_next != iff8sp_pkg::TAG_8SVX) begin
                            has_res  = 1'b1;
                            res_kind = iff8sp_pkg::KIND_NOT_8SVX;
                            ending   = 1'b1;
                        end else if (running_total_reg >= form_length_reg) begin
                            ending = 1'b1;
                        end else begin
                            phase_next = PH_CHUNK_HDR;
                        end
                    end
                end
                PH_CHUNK_HDR: begin
                    byte_index_next = bi_inc;
                    if (bi_inc == 5'd4) begin
                        chunk_tag_next = field_shift_next;
                    end else if (bi_inc >= 5'd8) begin
                        // Header complete: account for the length and dispatch.
                        byte_index_next      = 5'd0;
                        chunk_remaining_next = field_shift_next;
                        running_total_next   = total_sum;
                        end_total            = total_sum;
                        if (chunk_tag_reg == iff8sp_pkg::TAG_VHDR) begin
                            phase_next = PH_VHDR;
                        end else if (chunk_tag_reg == iff8sp_pkg::TAG_BODY) begin
                            if (oct_used == 8'd0 || unit == 32'd0) begin
                                do_chunk_end = 1'b1;
                            end else begin
                                current_octave_next = 4'd0;
                                body_remaining_next = {4'd0, unit};
                                oct_len_next        = {4'd0, unit};
                                phase_next          = PH_BODY;
                            end
                        end else if (chunk_tag_reg == iff8sp_pkg::TAG_ANNO ||
                                     chunk_tag_reg == iff8sp_pkg::TAG_NAME ||
                                     chunk_tag_reg == iff8sp_pkg::TAG_AUTH ||
                                     chunk_tag_reg == iff8sp_pkg::TAG_COPY) begin
                            if (field_shift_next == 32'd0) begin
                                do_chunk_end = 1'b1;
                            end else begin
                                phase_next = PH_TEXT;
                            end
                        end else begin
                            if (field_shift_next == 32'd0) begin
                                do_chunk_end = 1'b1;
                            end else begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                end
                PH_VHDR: begin
                    // Every fourth byte completes one header word.
                    byte_index_next = bi_inc;
                    if (bi_inc[1:0] == 2'd0) begin
                        for (int i = 0; i < 5; i++) begin
                            if (hs_index == 3'(i)) begin
                                hs_next[i] = field_shift_next;
                            end
                        end
                    end
                    if (bi_inc >= iff8sp_pkg::VHDR_BYTES) begin
                        byte_index_next = 5'd0;
                        has_res         = 1'b1;
                        res_kind        = iff8sp_pkg::KIND_HEADER;
                        do_chunk_end    = 1'b1;
                    end
                end
                PH_TEXT: begin
                    has_res              = 1'b1;
                    res_kind             = iff8sp_pkg::KIND_TEXT;
                    res_payload          = in_byte;
                    chunk_remaining_next = chunk_remaining_reg - 32'd1;
                    if (chunk_remaining_next == 32'd0) begin
                        do_chunk_end = 1'b1;
                    end
                end
                PH_SKIP: begin
                    chunk_remaining_next = chunk_remaining_reg - 32'd1;
                    if (chunk_remaining_next == 32'd0) begin
                        do_chunk_end = 1'b1;
                    end
                end
                PH_BODY: begin
                    // Octave l holds unit * (l + 1) bytes; the length grows by unit.
                    has_res             = 1'b1;
                    res_kind            = iff8sp_pkg::KIND_SAMPLE;
                    res_payload         = in_byte;
                    res_octave          = current_octave_reg;
                    body_remaining_next = body_remaining_reg - 36'd1;
                    if (body_remaining_next == 36'd0) begin
                        if ({3'd0, oct_following} < oct_used) begin
                            current_octave_next = oct_following[3:0];
                            oct_len_next        = oct_len_reg + {4'd0, unit};
                            body_remaining_next = oct_len_next;
                        end else begin
                            do_chunk_end = 1'b1;
                        end
                    end
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase

            // Chunk boundary: stop once the summed lengths reach the FORM length.
            if (do_chunk_end) begin
                if (end_total >= form_length_reg) begin
                    ending = 1'b1;
                end else begin
                    phase_next      = PH_CHUNK_HDR;
                    byte_index_next = 5'd0;
                end
            end

            if (in_final) begin
                ending = 1'b1;
            end
            if (ending) begin
                phase_next = PH_DONE;
                if (!has_res) begin
                    has_res  = 1'b1;
                    res_kind = iff8sp_pkg::KIND_END;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_FORM_ID;
            field_shift_reg     <= 32'd0;
            byte_index_reg      <= 5'd0;
            form_length_reg     <= 32'd0;
            running_total_reg   <= 32'd0;
            chunk_tag_reg       <= 32'd0;
            chunk_remaining_reg <= 32'd0;
            for (int i = 0; i < 5; i++) begin
                hs_reg[i] <= 32'd0;
            end
            body_remaining_reg  <= 36'd0;
            oct_len_reg         <= 36'd0;
            current_octave_reg  <= 4'd0;
        end else begin
            phase_reg           <= phase_next;
            field_shift_reg     <= field_shift_next;
            byte_index_reg      <= byte_index_next;
            form_length_reg     <= form_length_next;
            running_total_reg   <= running_total_next;
            chunk_tag_reg       <= chunk_tag_next;
            chunk_remaining_reg <= chunk_remaining_next;
            for (int i = 0; i < 5; i++) begin
                hs_reg[i] <= hs_next[i];
            end
            body_remaining_reg  <= body_remaining_next;
            oct_len_reg         <= oct_len_next;
            current_octave_reg  <= current_octave_next;
        end
    end

    // Result of this byte and the header as the header registers hold it.
    assign res.valid   = accept && has_res;
    assign res.kind    = res_kind;
    assign res.payload = res_payload;
    assign res.octave  = res_octave;
    assign res.done    = ending;

    assign hdr.oneshot       = hs_reg[0];
    assign hdr.repeats       = hs_reg[1];
    assign hdr.cycle         = hs_reg[2];
    assign hdr.rate_oct_comp = hs_reg[3];
    assign hdr.volume        = hs_reg[4];

    // Once the parse is over it stays over and stays silent.
    `ASSERT_NEXT(a_done_sticky, aclk, aresetn, phase_reg == PH_DONE, phase_reg == PH_DONE)
    `ASSERT_IMPL(a_done_silent, aclk, aresetn, accept && phase_reg == PH_DONE, !res.valid)
    `ASSERT_IMPL(a_octave_range, aclk, aresetn,
        res.valid && res.kind == iff8sp_pkg::KIND_SAMPLE,
        {1'b0, res.octave} < 5'(MAX_OCTAVES))
    `ASSERT_IMPL(a_stop_kinds_done, aclk, aresetn,
        res.valid && (res.kind == iff8sp_pkg::KIND_NOT_FORM ||
        res.kind == iff8sp_pkg::KIND_NOT_8SVX || res.kind == iff8sp_pkg::KIND_END),
        res.done)

endmodule

// File: src/iff8sp_out_reg.sv
// Result register of the IFF 8SVX stream parser, with upstream ready.
// Depends on iff8sp_pkg.
module iff8sp_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load_en,
    input  iff8sp_pkg::result_t res_in,
    input  logic                out_ready,
    output logic                in_ready,
    output iff8sp_pkg::result_t res_out
);

    logic                valid_reg, valid_next;
    iff8sp_pkg::result_t data_reg, data_next;

    // A new word may enter when the register is empty or being emptied.
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load_en && res_in.valid) begin
            valid_next = 1'b1;
            data_next  = res_in;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    always_comb begin
        res_out       = data_reg;
        res_out.valid = valid_reg;
    end

endmodule
